>>> rtl/queue_with_positional_insert_macros.svh
// Assertion macros shared by the queue RTL.
// Each check is clocked on the rising edge and disabled while reset is low.
`ifndef QUEUE_WITH_POSITIONAL_INSERT_MACROS_SVH
`define QUEUE_WITH_POSITIONAL_INSERT_MACROS_SVH

`ifndef SYNTHESIS

// Check a property that must hold at every edge out of reset.
`define QWPI_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (prop)) \
        else $error(msg);

// Check that a condition leads to a consequence at the next edge.
`define QWPI_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`else

`define QWPI_ASSERT(lbl, clk, rst_n, prop, msg)
`define QWPI_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg)

`endif

`endif

>>> rtl/qwpi_pkg.sv
package qwpi_pkg;

    localparam int QUEUE_DEPTH = 16;
    localparam int IDX_W       = $clog2(QUEUE_DEPTH);
    localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);
    localparam int CMP_W       = (CNT_W > 8) ? CNT_W : 8;

    localparam logic [1:0] MODE_APPEND = 2'd0;
    localparam logic [1:0] MODE_INSERT = 2'd1;
    localparam logic [1:0] MODE_REMOVE = 2'd2;

    localparam logic [1:0] ST_DONE  = 2'd0;
    localparam logic [1:0] ST_EMPTY = 2'd1;
    localparam logic [1:0] ST_FULL  = 2'd2;

    // Operation broadcast to every slot cell in the accepting cycle.
    typedef struct packed {
        logic             add;
        logic             rem;
        logic [IDX_W-1:0] idx;
        logic [CNT_W-1:0] count;
    } t_op;

    // Low five bits of the count, zero extended when the count is narrower.
    function automatic logic [4:0] count_field(input logic [CNT_W-1:0] c);
        logic [CNT_W+4:0] w;
        w = {5'b0, c};
        return w[4:0];
    endfunction

endpackage

>>> rtl/qwpi_cell.sv
module qwpi_cell (
    input  logic                      i_clk,
    input  logic [qwpi_pkg::IDX_W-1:0] i_slot,
    input  qwpi_pkg::t_op             i_op,
    input  logic [63:0]               i_new_name,
    input  logic [63:0]               i_new_id,
    input  logic [63:0]               i_prev_name,
    input  logic [63:0]               i_prev_id,
    input  logic [63:0]               i_next_name,
    input  logic [63:0]               i_next_id,
    output logic [63:0]               o_name,
    output logic [63:0]               o_id
);
    import qwpi_pkg::*;

    logic [63:0]      r_name, r_id;
    logic [63:0]      n_name, n_id;
    logic [CNT_W-1:0] slot_ext;
    logic [CNT_W-1:0] idx_ext;

    assign slot_ext = CNT_W'(i_slot);
    assign idx_ext  = CNT_W'(i_op.idx);

    // Load the new entry, shift from a neighbor, or hold.
    always_comb begin
        n_name = r_name;
        n_id   = r_id;
        if (i_op.add) begin
            if (slot_ext == idx_ext) begin
                n_name = i_new_name;
                n_id   = i_new_id;
            end else if (slot_ext > idx_ext && slot_ext <= i_op.count) begin
                n_name = i_prev_name;
                n_id   = i_prev_id;
            end
        end else if (i_op.rem) begin
            if (slot_ext + CNT_W'(1) < i_op.count) begin
                n_name = i_next_name;
                n_id   = i_next_id;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_name <= n_name;
        r_id   <= n_id;
    end

    assign o_name = r_name;
    assign o_id   = r_id;

endmodule

>>> rtl/qwpi_ctrl.sv
`include "queue_with_positional_insert_macros.svh"

module qwpi_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    output logic          o_ready,
    input  logic [1:0]    i_mode,
    input  logic [7:0]    i_position,
    input  logic [63:0]   i_head_name,
    input  logic [63:0]   i_head_id,
    output qwpi_pkg::t_op o_op,
    output logic          o_valid,
    input  logic          i_ready,
    output logic [1:0]    o_status,
    output logic [63:0]   o_removed_name,
    output logic [63:0]   o_removed_id,
    output logic [4:0]    o_entry_count
);
    import qwpi_pkg::*;

    typedef struct packed {
        logic [1:0]  status;
        logic [63:0] name;
        logic [63:0] id;
        logic [4:0]  count;
    } t_result;

    logic [CNT_W-1:0] r_count, n_count;
    logic             r_out_valid, r_skid_valid;
    t_result          r_out, r_skid;
    t_result          new_res;
    logic             in_fire, out_fire;
    logic             full, empty;
    logic [IDX_W-1:0] ins_idx;
    logic [CMP_W-1:0] pos_ext, cnt_ext;

    assign o_ready  = !r_skid_valid;
    assign in_fire  = i_valid && o_ready;
    assign out_fire = r_out_valid && i_ready;
    assign full     = (r_count == CNT_W'(QUEUE_DEPTH));
    assign empty    = (r_count == '0);
    assign pos_ext  = CMP_W'(i_position);
    assign cnt_ext  = CMP_W'(r_count);

    // Slot index of an added entry.
    always_comb begin
        if (i_mode == MODE_APPEND || empty || pos_ext > cnt_ext) begin
            ins_idx = IDX_W'(r_count);
        end else if (i_position == 8'd0) begin
            ins_idx = IDX_W'(1);
        end else begin
            ins_idx = IDX_W'(i_position - 8'd1);
        end
    end

    always_comb begin
        o_op.add       = 1'b0;
        o_op.rem       = 1'b0;
        o_op.idx       = ins_idx;
        o_op.count     = r_count;
        n_count        = r_count;
        new_res.status = ST_DONE;
        new_res.name   = '0;
        new_res.id     = '0;
        unique case (i_mode) inside
            MODE_APPEND, MODE_INSERT: begin
                if (full) begin
                    new_res.status = ST_FULL;
                end else begin
                    o_op.add = in_fire;
                    n_count  = r_count + CNT_W'(1);
                end
            end
            MODE_REMOVE: begin
                if (empty) begin
                    new_res.status = ST_EMPTY;
                end else begin
                    o_op.rem     = in_fire;
                    n_count      = r_count - CNT_W'(1);
                    new_res.name = i_head_name;
                    new_res.id   = i_head_id;
                end
            end
            default: begin
            end
        endcase
        new_res.count = count_field(n_count);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count      <= '0;
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else begin
            if (in_fire) begin
                r_count <= n_count;
            end
            if (out_fire || !r_out_valid) begin
                if (r_skid_valid) begin
                    r_out_valid  <= 1'b1;
                    r_skid_valid <= 1'b0;
                end else begin
                    r_out_valid <= in_fire;
                end
            end else if (in_fire) begin
                r_skid_valid <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_fire || !r_out_valid) begin
            r_out <= r_skid_valid ? r_skid : new_res;
        end else if (in_fire) begin
            r_skid <= new_res;
        end
    end

    assign o_valid        = r_out_valid;
    assign o_status       = r_out.status;
    assign o_removed_name = r_out.name;
    assign o_removed_id   = r_out.id;
    assign o_entry_count  = r_out.count;

    `QWPI_ASSERT(a_count_bound, i_clk, i_rst_n,
        r_count <= CNT_W'(QUEUE_DEPTH), "count above depth")
    `QWPI_ASSERT(a_skid_behind_out, i_clk, i_rst_n,
        !r_skid_valid || r_out_valid, "skid without out")
    `QWPI_ASSERT_NEXT(a_full_drop, i_clk, i_rst_n,
        in_fire && full && i_mode != MODE_REMOVE, $stable(r_count),
        "add to full queue changed count")
    `QWPI_ASSERT_NEXT(a_skid_fill, i_clk, i_rst_n,
        in_fire && r_out_valid && !i_ready, r_skid_valid, "stalled request lost")

endmodule

>>> rtl/queue_with_positional_insert.sv
// Channel   | Handshake          | Payload
// ----------+--------------------+--------------------------------------------
// request   | i_valid / o_ready  | i_mode, i_position, i_name_word, i_id_word
// result    | o_valid / i_ready  | o_status, o_removed_name, o_removed_id,
//           |                    | o_entry_count
//
// One request is taken per cycle while o_ready is high; its result is registered
// as each slot cell loads, shifts from a neighbor or holds in a single step.
// A two-entry result buffer (output register plus skid) drops o_ready only
// when two results are waiting on i_ready.
// Reset clears the entry count and the result valid flags; slot contents are
// left as they are and are never read before being written.
module queue_with_positional_insert (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [1:0]  i_mode,
    input  logic [7:0]  i_position,
    input  logic [63:0] i_name_word,
    input  logic [63:0] i_id_word,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [1:0]  o_status,
    output logic [63:0] o_removed_name,
    output logic [63:0] o_removed_id,
    output logic [4:0]  o_entry_count
);
    import qwpi_pkg::*;

    // Operation broadcast to all cells; gated by request acceptance.
    t_op         op;
    // Slot contents, head at index zero.
    logic [63:0] slot_name [QUEUE_DEPTH];
    logic [63:0] slot_id   [QUEUE_DEPTH];

    // Decode the request, track the count and buffer the results.
    qwpi_ctrl u_ctrl (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .o_ready        (o_ready),
        .i_mode         (i_mode),
        .i_position     (i_position),
        .i_head_name    (slot_name[0]),
        .i_head_id      (slot_id[0]),
        .o_op           (op),
        .o_valid        (o_valid),
        .i_ready        (i_ready),
        .o_status       (o_status),
        .o_removed_name (o_removed_name),
        .o_removed_id   (o_removed_id),
        .o_entry_count  (o_entry_count)
    );

    // Row of slot cells; each sees its neighbors toward head and tail.
    // The head cell has no predecessor and the tail cell no successor,
    // so those inputs are tied to zero and never selected.
    for (genvar g = 0; g < QUEUE_DEPTH; g++) begin : g_slot
        logic [63:0] prev_name, prev_id, next_name, next_id;

        if (g == 0) begin : g_head
            assign prev_name = '0;
            assign prev_id   = '0;
        end else begin : g_mid_prev
            assign prev_name = slot_name[g-1];
            assign prev_id   = slot_id[g-1];
        end

        if (g == QUEUE_DEPTH - 1) begin : g_tail
            assign next_name = '0;
            assign next_id   = '0;
        end else begin : g_mid_next
            assign next_name = slot_name[g+1];
            assign next_id   = slot_id[g+1];
        end

        qwpi_cell u_cell (
            .i_clk       (i_clk),
            .i_slot      (IDX_W'(g)),
            .i_op        (op),
            .i_new_name  (i_name_word),
            .i_new_id    (i_id_word),
            .i_prev_name (prev_name),
            .i_prev_id   (prev_id),
            .i_next_name (next_name),
            .i_next_id   (next_id),
            .o_name      (slot_name[g]),
            .o_id        (slot_id[g])
        );
    end

endmodule
